### hw/rtl/qtl_pkg.sv
// shared types, codes and byte classifiers for the query text lexer
package qtl_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // token kinds as seen on the result port
  localparam logic [2:0] KIND_SYM   = 3'd0;
  localparam logic [2:0] KIND_STR   = 3'd1;
  localparam logic [2:0] KIND_NUM   = 3'd2;
  localparam logic [2:0] KIND_IDENT = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  // lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_NUM   = 3'd1;
  localparam logic [2:0] MODE_IDENT = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_PEND  = 3'd4;

  // character codes
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // one result word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_done;
  } res_t;

  // one queue entry: the one or two results of an input word
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // outcome of lexing one byte from idle
  typedef struct packed {
    logic       v;
    res_t       r;
    logic [2:0] mode;
    logic [7:0] held;
  } idle_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic has, logic done);
    res_t r;
    r.kind       = kind;
    r.text_byte  = has ? b : 8'h00;
    r.has_byte   = has;
    r.token_done = done;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic ident_start(logic [7:0] c);
    return is_alpha(c) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_BSLASH);
  endfunction

  // lex one byte starting from idle
  function automatic idle_t lex_idle(logic [7:0] c);
    idle_t o;
    o.v    = 1'b0;
    o.r    = mk_res(KIND_SYM, 8'h00, 1'b0, 1'b0);
    o.mode = MODE_IDLE;
    o.held = 8'h00;
    if (is_space(c)) begin
      o.v = 1'b0;
    end else if ((c == CH_SEMI) || (c == CH_EQ) || (c == CH_LPAR) || (c == CH_RPAR) ||
                 (c == CH_COMMA) || (c == CH_STAR)) begin
      o.v = 1'b1;
      o.r = mk_res(KIND_SYM, c, 1'b1, 1'b1);
    end else if (c == CH_QUOTE) begin
      o.mode = MODE_STR;
    end else if ((c == CH_LT) || (c == CH_GT) || (c == CH_BANG)) begin
      o.mode = MODE_PEND;
      o.held = c;
    end else if (is_digit(c)) begin
      o.v    = 1'b1;
      o.r    = mk_res(KIND_NUM, c, 1'b1, 1'b0);
      o.mode = MODE_NUM;
    end else if (ident_start(c)) begin
      o.v    = 1'b1;
      o.r    = mk_res(KIND_IDENT, c, 1'b1, 1'b0);
      o.mode = MODE_IDENT;
    end
    return o;
  endfunction

endpackage

### hw/rtl/qtl_front.sv
// front part: lexer state and classification of each accepted byte
module qtl_front import qtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic       finish_i,
  input  logic       push,
  input  logic       full,
  output logic       wr_en_o,
  output entry_t     wr_entry_o
);

  logic [2:0] mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  idle_t      idle;
  logic       a_v, b_v;
  res_t       a_r, b_r;
  logic       held_sym;
  logic       joined;

  assign accept   = push && !full;
  assign idle     = lex_idle(ch_i);
  assign held_sym = (held_q == CH_LT) || (held_q == CH_GT);
  assign joined   = ((held_q == CH_LT) && ((ch_i == CH_EQ) || (ch_i == CH_GT))) ||
                    (((held_q == CH_GT) || (held_q == CH_BANG)) && (ch_i == CH_EQ));

  // next state and up to two results for this word
  always_comb begin
    a_v    = 1'b0;
    b_v    = 1'b0;
    a_r    = mk_res(KIND_SYM, 8'h00, 1'b0, 1'b0);
    b_r    = mk_res(KIND_SYM, 8'h00, 1'b0, 1'b0);
    mode_d = mode_q;
    held_d = held_q;
    if (finish_i) begin
      unique case (mode_q)
        MODE_NUM: begin
          a_v = 1'b1;
          a_r = mk_res(KIND_NUM, 8'h00, 1'b0, 1'b1);
        end
        MODE_IDENT: begin
          a_v = 1'b1;
          a_r = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b1);
        end
        MODE_STR: begin
          a_v = 1'b1;
          a_r = mk_res(KIND_STR, 8'h00, 1'b0, 1'b1);
        end
        MODE_PEND: begin
          a_v = held_sym;
          a_r = mk_res(KIND_SYM, held_q, 1'b1, 1'b1);
        end
        default: begin
          a_v = 1'b0;
        end
      endcase
      b_v    = 1'b1;
      b_r    = mk_res(KIND_END, 8'h00, 1'b0, 1'b1);
      mode_d = MODE_IDLE;
      held_d = 8'h00;
    end else begin
      unique case (mode_q)
        MODE_NUM: begin
          if (is_digit(ch_i)) begin
            a_v = 1'b1;
            a_r = mk_res(KIND_NUM, ch_i, 1'b1, 1'b0);
          end else begin
            a_v    = 1'b1;
            a_r    = mk_res(KIND_NUM, 8'h00, 1'b0, 1'b1);
            b_v    = idle.v;
            b_r    = idle.r;
            mode_d = idle.mode;
            held_d = idle.held;
          end
        end
        MODE_IDENT: begin
          if (ident_start(ch_i) || is_digit(ch_i)) begin
            a_v = 1'b1;
            a_r = mk_res(KIND_IDENT, ch_i, 1'b1, 1'b0);
          end else begin
            a_v    = 1'b1;
            a_r    = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b1);
            b_v    = idle.v;
            b_r    = idle.r;
            mode_d = idle.mode;
            held_d = idle.held;
          end
        end
        MODE_STR: begin
          a_v = 1'b1;
          if (ch_i == CH_QUOTE) begin
            a_r    = mk_res(KIND_STR, 8'h00, 1'b0, 1'b1);
            mode_d = MODE_IDLE;
          end else begin
            a_r = mk_res(KIND_STR, ch_i, 1'b1, 1'b0);
          end
        end
        MODE_PEND: begin
          if (joined) begin
            a_v    = 1'b1;
            a_r    = mk_res(KIND_SYM, held_q, 1'b1, 1'b0);
            b_v    = 1'b1;
            b_r    = mk_res(KIND_SYM, ch_i, 1'b1, 1'b1);
            mode_d = MODE_IDLE;
            held_d = 8'h00;
          end else begin
            // lone < or > becomes a symbol, lone ! is dropped
            a_v    = held_sym;
            a_r    = mk_res(KIND_SYM, held_q, 1'b1, 1'b1);
            b_v    = idle.v;
            b_r    = idle.r;
            mode_d = idle.mode;
            held_d = idle.held;
          end
        end
        default: begin
          b_v    = idle.v;
          b_r    = idle.r;
          mode_d = idle.mode;
          held_d = idle.held;
        end
      endcase
    end
  end

  // pack results into a queue entry
  always_comb begin
    wr_entry_o.two = a_v && b_v;
    wr_entry_o.r0  = a_v ? a_r : b_r;
    wr_entry_o.r1  = b_r;
  end

  assign wr_en_o = accept && (a_v || b_v);

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= 8'h00;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

### hw/rtl/qtl_fifo.sv
// short queue of result entries between front and back
module qtl_fifo import qtl_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  entry_t wr_entry_i,
  input  logic   rd_en_i,
  output head_t  head_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o       = (cnt_q == CntFull);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_wr        = wr_en_i && !full_o;
  assign do_rd        = rd_en_i && head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/qtl_back.sv
// back part: splits queue entries into single result words
module qtl_back import qtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  head_t      head_i,
  output logic       rd_en_o,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] kind_o,
  output logic [7:0] text_byte_o,
  output logic       has_byte_o,
  output logic       token_done_o,
  output logic       last_o
);

  logic out_valid_q, out_valid_d;
  res_t out_res_q;
  logic out_last_q;
  logic sub_q, sub_d;
  logic take, load, cur_last;
  res_t cur;

  assign take     = pop && out_valid_q;
  assign load     = head_i.valid && (!out_valid_q || take);
  assign cur      = sub_q ? head_i.entry.r1 : head_i.entry.r0;
  assign cur_last = !head_i.entry.two || sub_q;
  assign rd_en_o  = load && cur_last;

  // output register and sub-word select
  always_comb begin
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    if (load) begin
      out_valid_d = 1'b1;
      sub_d       = !cur_last;
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q  <= cur;
      out_last_q <= cur_last;
    end
  end

  assign empty        = !out_valid_q;
  assign kind_o       = out_res_q.kind;
  assign text_byte_o  = out_res_q.text_byte;
  assign has_byte_o   = out_res_q.has_byte;
  assign token_done_o = out_res_q.token_done;
  assign last_o       = out_last_q;

endmodule

### hw/rtl/query_text_lexer.sv
// top level of the streaming query text lexer
// The lexer takes one text byte (or a finish mark) per cycle whenever full is
// low, and turns the text into a token stream: each result word carries a
// token kind, one byte of token text, a token end flag and a flag for the last
// word caused by an input word. An input word gives zero, one or two result
// words; while pop is high, the result port delivers one word per cycle, so a
// run of inputs that each give two words drains at half a byte per cycle. A
// queue of QueueDepth entries between the lexer front and the result
// serializer absorbs such bursts and result-side stalls; full rises only when
// that queue is full. An accepted byte passes through the queue storage and
// then the output register before it reaches the result port.
module query_text_lexer import qtl_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic       finish_i,
  input  logic       push,
  output logic       full,
  output logic [2:0] kind_o,
  output logic [7:0] text_byte_o,
  output logic       has_byte_o,
  output logic       token_done_o,
  output logic       last_o,
  output logic       empty,
  input  logic       pop
);

  logic   wr_en, rd_en;
  entry_t wr_entry;
  head_t  head;

  // lexer front
  qtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_i       (ch_i),
    .finish_i   (finish_i),
    .push       (push),
    .full       (full),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry)
  );

  // entry queue
  qtl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .head_o     (head),
    .full_o     (full)
  );

  // result serializer
  qtl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .rd_en_o      (rd_en),
    .pop          (pop),
    .empty        (empty),
    .kind_o       (kind_o),
    .text_byte_o  (text_byte_o),
    .has_byte_o   (has_byte_o),
    .token_done_o (token_done_o),
    .last_o       (last_o)
  );

endmodule

### test/query_text_lexer_tb.sv
// testbench for query_text_lexer: directed and random text against a token predictor
module query_text_lexer_tb;
  import qtl_pkg::*;

  // byte range bounds used by the classifiers and the stimulus
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_MAX  = 8'hFF;

  localparam int unsigned RandomWords = 110;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;

  // one result word as seen on the result ports
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text;
    logic       has;
    logic       done;
    logic       last;
  } token_word_t;

  // token predictor and store of expected result words
  class lexer_scoreboard;
    logic [2:0]  mode;
    logic [7:0]  held;
    token_word_t tokens_due[$];
    token_word_t step_words[$];
    int          fails;

    function new();
      mode  = MODE_IDLE;
      held  = 8'h00;
      fails = 0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit is_num_ch(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function bit is_name_start(logic [7:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
             (c == CH_UNDER) || (c == CH_DOT) || (c == CH_BSLASH);
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] b, logic has, logic done);
      token_word_t t;
      t.kind = kind;
      t.text = has ? b : 8'h00;
      t.has  = has;
      t.done = done;
      t.last = 1'b0;
      step_words.insert(step_words.size(), t);
    endfunction

    // lex a byte with nothing open
    function void from_idle(logic [7:0] c);
      mode = MODE_IDLE;
      if ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR))) begin
        return;
      end
      if ((c == CH_SEMI) || (c == CH_EQ) || (c == CH_LPAR) || (c == CH_RPAR) ||
          (c == CH_COMMA) || (c == CH_STAR)) begin
        emit(KIND_SYM, c, 1'b1, 1'b1);
      end else if (c == CH_QUOTE) begin
        mode = MODE_STR;
      end else if ((c == CH_LT) || (c == CH_GT) || (c == CH_BANG)) begin
        mode = MODE_PEND;
        held = c;
      end else if (is_num_ch(c)) begin
        mode = MODE_NUM;
        emit(KIND_NUM, c, 1'b1, 1'b0);
      end else if (is_name_start(c)) begin
        mode = MODE_IDENT;
        emit(KIND_IDENT, c, 1'b1, 1'b0);
      end
    endfunction

    // a held < or > becomes a symbol, a held ! is dropped
    function void flush_held();
      if ((held == CH_LT) || (held == CH_GT)) emit(KIND_SYM, held, 1'b1, 1'b1);
      mode = MODE_IDLE;
      held = 8'h00;
    endfunction

    // predict the words caused by one accepted input word
    function void note_word(logic [7:0] c, logic fin);
      token_word_t t;
      step_words.delete();
      if (fin) begin
        case (mode)
          MODE_NUM:   emit(KIND_NUM, 8'h00, 1'b0, 1'b1);
          MODE_IDENT: emit(KIND_IDENT, 8'h00, 1'b0, 1'b1);
          MODE_STR:   emit(KIND_STR, 8'h00, 1'b0, 1'b1);
          MODE_PEND:  flush_held();
          default: ;
        endcase
        emit(KIND_END, 8'h00, 1'b0, 1'b1);
        mode = MODE_IDLE;
        held = 8'h00;
      end else begin
        case (mode)
          MODE_NUM: begin
            if (is_num_ch(c)) begin
              emit(KIND_NUM, c, 1'b1, 1'b0);
            end else begin
              emit(KIND_NUM, 8'h00, 1'b0, 1'b1);
              from_idle(c);
            end
          end
          MODE_IDENT: begin
            if (is_name_start(c) || is_num_ch(c)) begin
              emit(KIND_IDENT, c, 1'b1, 1'b0);
            end else begin
              emit(KIND_IDENT, 8'h00, 1'b0, 1'b1);
              from_idle(c);
            end
          end
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              emit(KIND_STR, 8'h00, 1'b0, 1'b1);
              mode = MODE_IDLE;
            end else begin
              emit(KIND_STR, c, 1'b1, 1'b0);
            end
          end
          MODE_PEND: begin
            if (((held == CH_LT) && ((c == CH_EQ) || (c == CH_GT))) ||
                (((held == CH_GT) || (held == CH_BANG)) && (c == CH_EQ))) begin
              emit(KIND_SYM, held, 1'b1, 1'b0);
              emit(KIND_SYM, c, 1'b1, 1'b1);
              mode = MODE_IDLE;
              held = 8'h00;
            end else begin
              flush_held();
              from_idle(c);
            end
          end
          default: from_idle(c);
        endcase
      end
      if (step_words.size() > 0) begin
        t = step_words[step_words.size() - 1];
        t.last = 1'b1;
        step_words[step_words.size() - 1] = t;
      end
      foreach (step_words[i]) tokens_due.insert(tokens_due.size(), step_words[i]);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(token_word_t got);
      token_word_t exp;
      if (tokens_due.size() == 0) begin
        $error("unexpected result word: kind %0d text_byte %0h", got.kind, got.text);
        fails++;
        return;
      end
      exp = tokens_due.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        fails++;
      end
      if (got.text !== exp.text) begin
        $error("text_byte: expected %0h, got %0h", exp.text, got.text);
        fails++;
      end
      if (got.has !== exp.has) begin
        $error("has_byte: expected %0b, got %0b", exp.has, got.has);
        fails++;
      end
      if (got.done !== exp.done) begin
        $error("token_done: expected %0b, got %0b", exp.done, got.done);
        fails++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic [7:0] ch_i     = 8'h00;
  logic       finish_i = 1'b0;
  logic       push     = 1'b0;
  logic       full;
  logic [2:0] kind_o;
  logic [7:0] text_byte_o;
  logic       has_byte_o;
  logic       token_done_o;
  logic       last_o;
  logic       empty;
  logic       pop      = 1'b0;

  lexer_scoreboard board = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned token_words = 0;
  logic [5:0]  stall_tick  = '0;
  logic [15:0] stall_mask  = '1;

  query_text_lexer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (ch_i),
    .finish_i     (finish_i),
    .push         (push),
    .full         (full),
    .kind_o       (kind_o),
    .text_byte_o  (text_byte_o),
    .has_byte_o   (has_byte_o),
    .token_done_o (token_done_o),
    .last_o       (last_o),
    .empty        (empty),
    .pop          (pop)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls on a random mask that is renewed each time the tick counter wraps
  always @(posedge clk_i) begin
    if (stall_tick == 0) stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    stall_tick <= stall_tick + 1'b1;
    pop <= stall_mask[stall_tick[3:0]];
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      board.check_word('{kind_o, text_byte_o, has_byte_o, token_done_o, last_o});
    end
  end

  // push one word, in bursts with random gaps between them
  task automatic send_word(logic [7:0] c, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    push     <= 1'b1;
    ch_i     <= c;
    finish_i <= fin;
    do @(posedge clk_i); while (full);
    board.note_word(c, fin);
    burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] name_start_byte();
    int unsigned r;
    r = $urandom_range(0, 54);
    if (r < 26) return 8'(CH_UP_A + r);
    if (r < 52) return 8'(CH_LO_A + (r - 26));
    if (r == 52) return CH_UNDER;
    if (r == 53) return CH_DOT;
    return CH_BSLASH;
  endfunction

  function automatic logic [7:0] name_byte();
    if ($urandom_range(0, 3) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
    return name_start_byte();
  endfunction

  // one random fragment of query text, mostly well formed
  task automatic send_fragment();
    logic [7:0] b;
    int unsigned n;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        token_words += n;
      end
      1, 2: begin
        n = $urandom_range(0, 5);
        send_word(name_start_byte(), 1'b0);
        repeat (n) send_word(name_byte(), 1'b0);
        token_words += n + 1;
      end
      3: begin
        n = $urandom_range(0, 5);
        send_word(CH_QUOTE, 1'b0);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          send_word(b, 1'b0);
        end
        token_words += n + 1;
        // now and then the string stays open
        if ($urandom_range(0, 9) != 0) begin
          send_word(CH_QUOTE, 1'b0);
          token_words++;
        end
      end
      4: begin
        case ($urandom_range(0, 5))
          0: b = CH_SEMI;
          1: b = CH_EQ;
          2: b = CH_LPAR;
          3: b = CH_RPAR;
          4: b = CH_COMMA;
          default: b = CH_STAR;
        endcase
        send_word(b, 1'b0);
        token_words++;
      end
      5: begin
        case ($urandom_range(0, 2))
          0: b = CH_LT;
          1: b = CH_GT;
          default: b = CH_BANG;
        endcase
        send_word(b, 1'b0);
        case ($urandom_range(0, 3))
          0, 1: send_word(CH_EQ, 1'b0);
          2: send_word(CH_GT, 1'b0);
          default: send_word(8'($urandom_range(0, 255)), 1'b0);
        endcase
        token_words += 2;
      end
      6: begin
        b = ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
        send_word(b, 1'b0);
      end
      7: begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
        token_words++;
      end
    endcase
  endtask

  // stimulus and end of run
  initial begin
    bit drained;
    drained = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // joined symbols, lone bang, number then name, empty string, all symbols,
    // held greater-than flushed by a quote, unterminated string at finish
    send_text("<=>=!=<>!x;12_.\\''=(),*>'");
    send_word(CH_MAX, 1'b0);
    send_word(CH_MAX, 1'b1);

    while (token_words < RandomWords) begin
      send_fragment();
      // hold off until every expected word has come
      if (!drained && token_words >= RandomWords / 2) begin
        drained = 1'b1;
        push <= 1'b0;
        do @(posedge clk_i); while (board.pending() != 0);
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
    push <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d result words never arrived", board.pending());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/qtl_pkg.sv
hw/rtl/qtl_front.sv
hw/rtl/qtl_fifo.sv
hw/rtl/qtl_back.sv
hw/rtl/query_text_lexer.sv
test/query_text_lexer_tb.sv
